// ===== src/uart_register_file_rx_fifo_unit_assert.svh =====
// Assertion macros used by the UART register file receive FIFO.
`ifndef UART_REGISTER_FILE_RX_FIFO_UNIT_ASSERT_SVH
`define UART_REGISTER_FILE_RX_FIFO_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define UART_RF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define UART_RF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UART_RF_ASSERT(label, clk, rst, prop, msg)
`define UART_RF_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== src/uart_rf_pkg.sv =====
// Types, codes and helper functions for the UART register file.
package uart_rf_pkg;

   localparam int DEF_RX_DEPTH = 16;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_HOST  = 2'd2;

   localparam logic [2:0] OFF_RBR_THR = 3'd0;
   localparam logic [2:0] OFF_IER     = 3'd1;
   localparam logic [2:0] OFF_IIR_FCR = 3'd2;
   localparam logic [2:0] OFF_LCR     = 3'd3;
   localparam logic [2:0] OFF_MCR     = 3'd4;
   localparam logic [2:0] OFF_LSR     = 3'd5;
   localparam logic [2:0] OFF_MSR     = 3'd6;
   localparam logic [2:0] OFF_SCR     = 3'd7;

   localparam logic [7:0] IID_RLS    = 8'h06;
   localparam logic [7:0] IID_RDA    = 8'h04;
   localparam logic [7:0] IID_THRE   = 8'h02;
   localparam logic [7:0] IID_NONE   = 8'h01;
   localparam logic [7:0] IIR_FIFO   = 8'hc0;
   localparam logic [7:0] MSR_IDLE   = 8'hb0;
   localparam logic [7:0] LSR_BASE   = 8'h60;
   localparam logic [7:0] LSR_DR     = 8'h01;
   localparam logic [7:0] LSR_OE     = 8'h02;

   typedef struct packed {
      logic [1:0] opcode;
      logic [2:0] reg_offset;
      logic [7:0] write_data;
      logic [7:0] rx_byte;
      logic       rx_last;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       rx_accepted;
      logic       irq_line;
   } rsp_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic       clear;
      logic [7:0] wdata;
   } fifo_ctl_type;

   typedef struct packed {
      logic       empty;
      logic       full;
      logic       one_left;
      logic [7:0] head_data;
   } fifo_sts_type;

   function automatic logic [7:0] pending_id(input logic [7:0] ier, input logic ovr,
                                             input logic nonempty);
      logic [7:0] id;
      if (ier[2] && ovr) begin
         id = IID_RLS;
      end else if (ier[0] && nonempty) begin
         id = IID_RDA;
      end else if (ier[1]) begin
         id = IID_THRE;
      end else begin
         id = IID_NONE;
      end
      return id;
   endfunction

   function automatic logic [7:0] modem_status(input logic [7:0] mcr);
      logic [7:0] v;
      if (!mcr[4]) begin
         v = MSR_IDLE;
      end else begin
         v = {mcr[3], mcr[2], mcr[0], mcr[1], 4'h0};
      end
      return v;
   endfunction

endpackage

// ===== src/uart_register_file_rx_fifo_unit.sv =====
// 16550A-style UART register file with receive FIFO, usage notes:
// The request channel carries one bus read, one bus write or one host receive
// byte per request (req_opcode), with offset and data on their own ports.
// The response channel returns one response per request, in order: read data,
// the byte sent outward on a THR write, whether a host byte was taken, and the
// interrupt line level after the request.
// A request is held in an input register, then handled by the register decode
// and FIFO pointer logic, and lands in a response register: rsp_valid rises
// once the request has moved from the input register into the response
// register, which a stalled receiver can hold off. Throughput is one request
// per cycle while responses are taken; the FIFO memory is written at most once
// and read once per cycle, with the head byte read ahead into a register.
// While the response register is held by a stalled receiver, the input
// register keeps its request; req_ready drops only when both are occupied,
// and rises again in the cycle rsp_ready frees the response register.
// Reset clears all control registers, the FIFO pointers and both valid flags.
// FIFO contents are not cleared; only written entries are ever returned.
module uart_register_file_rx_fifo_unit
   import uart_rf_pkg::*;
#(
   parameter int RX_DEPTH = DEF_RX_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_opcode,
   input  logic [2:0] req_reg_offset,
   input  logic [7:0] req_write_data,
   input  logic [7:0] req_rx_byte,
   input  logic       req_rx_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_rx_accepted,
   output logic       rsp_irq_line
);

   logic         in_valid_ff, in_valid_in;
   req_type      in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_type      out_ff, result;
   logic         advance;
   fifo_ctl_type fifo_ctl;
   fifo_sts_type fifo_sts;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= '{opcode: req_opcode, reg_offset: req_reg_offset,
                         write_data: req_write_data, rx_byte: req_rx_byte,
                         rx_last: req_rx_last};
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   uart_rf_regs u_regs (
      .clock  (clock),
      .reset  (reset),
      .en     (advance),
      .item   (in_item_ff),
      .sts    (fifo_sts),
      .ctl    (fifo_ctl),
      .result (result)
   );

   uart_rf_rx_fifo #(
      .RX_DEPTH (RX_DEPTH)
   ) u_rx_fifo (
      .clock (clock),
      .reset (reset),
      .en    (advance),
      .ctl   (fifo_ctl),
      .sts   (fifo_sts)
   );

   assign rsp_valid       = out_valid_ff;
   assign rsp_read_data   = out_ff.read_data;
   assign rsp_tx_valid    = out_ff.tx_valid;
   assign rsp_tx_byte     = out_ff.tx_byte;
   assign rsp_rx_accepted = out_ff.rx_accepted;
   assign rsp_irq_line    = out_ff.irq_line;

endmodule

// ===== src/uart_rf_rx_fifo.sv =====
// Receive FIFO: byte memory, head pointer, fill count and prefetched head byte.
`include "uart_register_file_rx_fifo_unit_assert.svh"
module uart_rf_rx_fifo
   import uart_rf_pkg::*;
#(
   parameter int RX_DEPTH = DEF_RX_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  fifo_ctl_type ctl,
   output fifo_sts_type sts
);

   localparam int PTR_W = $clog2(RX_DEPTH);
   localparam int CNT_W = $clog2(RX_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(RX_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RX_DEPTH - 1);

   logic [7:0]       mem [RX_DEPTH];
   logic [PTR_W-1:0] head_ff, head_in, head_inc, wr_addr;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [SUM_W-1:0] wr_sum;
   logic [7:0]       head_data_ff;
   logic             empty, full, wr_en;

   assign empty    = (fill_ff == '0);
   assign full     = (fill_ff == CNT_W'(RX_DEPTH));
   assign head_inc = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
   assign wr_sum   = SUM_W'(head_ff) + SUM_W'(fill_ff);

   always_comb begin
      if (wr_sum >= DEPTH_S) begin
         wr_addr = PTR_W'(wr_sum - DEPTH_S);
      end else begin
         wr_addr = PTR_W'(wr_sum);
      end
   end

   assign wr_en = en && ctl.push && !full && !ctl.clear;

   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      if (en) begin
         if (ctl.clear) begin
            head_in = '0;
            fill_in = '0;
         end else if (ctl.push && !full) begin
            fill_in = fill_ff + 1'b1;
         end else if (ctl.pop && !empty) begin
            head_in = head_inc;
            fill_in = fill_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   // The head byte is read ahead so a pop finds it registered; a write into the
   // slot that becomes the head is forwarded.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= ctl.wdata;
      end
      if (wr_en && (wr_addr == head_in)) begin
         head_data_ff <= ctl.wdata;
      end else begin
         head_data_ff <= mem[head_in];
      end
   end

   assign sts.empty     = empty;
   assign sts.full      = full;
   assign sts.one_left  = (fill_ff == CNT_W'(1));
   assign sts.head_data = head_data_ff;

   `UART_RF_ASSERT(a_fill_bound, clock, reset, fill_ff <= CNT_W'(RX_DEPTH), "fill above depth")
   `UART_RF_ASSERT(a_no_push_full, clock, reset, !(en && ctl.push && full), "push into full FIFO")
   `UART_RF_ASSERT(a_no_pop_empty, clock, reset, !(en && ctl.pop && empty), "pop from empty FIFO")
   `UART_RF_ASSERT(a_clear_empties, clock, reset, (en && ctl.clear) |=> (fill_ff == '0 && head_ff == '0), "clear did not empty FIFO")

endmodule

// ===== src/uart_rf_regs.sv =====
// Register file: bus decode, control registers, overrun flag and result forming.
module uart_rf_regs
   import uart_rf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  req_type      item,
   input  fifo_sts_type sts,
   output fifo_ctl_type ctl,
   output rsp_type      result
);

   logic [7:0] ier_ff, ier_in, fcr_ff, fcr_in, lcr_ff, lcr_in, mcr_ff, mcr_in;
   logic [7:0] scr_ff, scr_in, dll_ff, dll_in, dlm_ff, dlm_in;
   logic       ovr_ff, ovr_in;
   logic       dlab, loopback, nonempty_after;
   logic [7:0] iir_val, lsr_val;

   assign dlab     = lcr_ff[7];
   assign loopback = mcr_ff[4];
   assign iir_val  = pending_id(ier_ff, ovr_ff, !sts.empty) | (fcr_ff[0] ? IIR_FIFO : 8'h00);
   assign lsr_val  = LSR_BASE | (sts.empty ? 8'h00 : LSR_DR) | (ovr_ff ? LSR_OE : 8'h00);

   always_comb begin
      ier_in = ier_ff;
      fcr_in = fcr_ff;
      lcr_in = lcr_ff;
      mcr_in = mcr_ff;
      scr_in = scr_ff;
      dll_in = dll_ff;
      dlm_in = dlm_ff;
      ovr_in = ovr_ff;
      ctl    = '0;
      result = '0;
      case (item.opcode)
         OP_READ: begin
            if (dlab && (item.reg_offset == OFF_RBR_THR)) begin
               result.read_data = dll_ff;
            end else if (dlab && (item.reg_offset == OFF_IER)) begin
               result.read_data = dlm_ff;
            end else begin
               case (item.reg_offset)
                  OFF_RBR_THR: begin
                     if (!sts.empty) begin
                        result.read_data = sts.head_data;
                        ctl.pop          = 1'b1;
                     end
                  end
                  OFF_IER:     result.read_data = ier_ff;
                  OFF_IIR_FCR: result.read_data = iir_val;
                  OFF_LCR:     result.read_data = lcr_ff;
                  OFF_MCR:     result.read_data = mcr_ff;
                  OFF_LSR: begin
                     result.read_data = lsr_val;
                     ovr_in           = 1'b0;
                  end
                  OFF_MSR:     result.read_data = modem_status(mcr_ff);
                  default:     result.read_data = scr_ff;
               endcase
            end
         end
         OP_WRITE: begin
            if (dlab && (item.reg_offset == OFF_RBR_THR)) begin
               dll_in = item.write_data;
            end else if (dlab && (item.reg_offset == OFF_IER)) begin
               dlm_in = item.write_data;
            end else begin
               case (item.reg_offset)
                  OFF_RBR_THR: begin
                     if (loopback) begin
                        if (sts.full) begin
                           ovr_in = 1'b1;
                        end else begin
                           ctl.push  = 1'b1;
                           ctl.wdata = item.write_data;
                        end
                     end else begin
                        result.tx_valid = 1'b1;
                        result.tx_byte  = item.write_data;
                     end
                  end
                  OFF_IER: ier_in = item.write_data;
                  OFF_IIR_FCR: begin
                     fcr_in = item.write_data;
                     if (item.write_data[1]) begin
                        ctl.clear = 1'b1;
                        ovr_in    = 1'b0;
                     end
                  end
                  OFF_LCR: lcr_in = item.write_data;
                  OFF_MCR: mcr_in = item.write_data;
                  OFF_SCR: scr_in = item.write_data;
                  default: ;
               endcase
            end
         end
         OP_HOST: begin
            if (!sts.full) begin
               ctl.push           = 1'b1;
               ctl.wdata          = item.rx_byte;
               result.rx_accepted = 1'b1;
            end
         end
         default: ;
      endcase
      // The interrupt line reflects the state this request leaves behind.
      nonempty_after  = ctl.push || (!sts.empty && !ctl.clear && !(ctl.pop && sts.one_left));
      result.irq_line = (pending_id(ier_in, ovr_in, nonempty_after) != IID_NONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ier_ff <= '0;
         fcr_ff <= '0;
         lcr_ff <= '0;
         mcr_ff <= '0;
         scr_ff <= '0;
         dll_ff <= '0;
         dlm_ff <= '0;
         ovr_ff <= 1'b0;
      end else if (en) begin
         ier_ff <= ier_in;
         fcr_ff <= fcr_in;
         lcr_ff <= lcr_in;
         mcr_ff <= mcr_in;
         scr_ff <= scr_in;
         dll_ff <= dll_in;
         dlm_ff <= dlm_in;
         ovr_ff <= ovr_in;
      end
   end

endmodule
